// ===== rtl/pwn_pkg.sv =====
// Package for the pink/white noise generator: shared types, stage tables,
// fixed-point rounding constants and register indexes.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package pwn_pkg;

  // Number of pink stages and the widths that follow from the stage tables.
  localparam int NUM_STAGES = 5;
  localparam int SUM_W      = 19;  // five Q3.12 values need three bits of growth
  localparam int PROD_W     = 35;  // amplitude (16 bits) times sum (19 bits)

  typedef logic [NUM_STAGES-1:0] stage_sel_t;
  typedef logic signed [15:0]    stage_val_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // Cumulative selection thresholds in Q0.16; a stage is chosen when the
  // selection word is at or below its threshold.
  localparam logic [15:0] THRESH [NUM_STAGES] = '{
    16'd130, 16'd969, 16'd4180, 16'd15321, 16'd60017
  };

  // Stage gains in Q3.12.
  localparam logic [14:0] GAIN [NUM_STAGES] = '{
    15'd15575, 15'd12163, 15'd10637, 15'd12644, 15'd13929
  };

  // Round-half-up bias for a shift by 15 bits.
  localparam int HALF_Q15 = 16384;

  // Pink scaling divides by 4096 * 500 = 2^14 * 125 with one rounding step.
  localparam int PINK_BIAS   = 1024000;  // half of 2048000
  localparam int PINK_SHIFT  = 14;
  localparam int DIV_OFFSET  = 4096;     // 125 * 4096 keeps the dividend positive
  localparam int DIV_BIAS    = 512000;
  localparam int RECIP_125   = 1073742;  // ceil(2^27 / 125)
  localparam int RECIP_SHIFT = 27;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_ENABLE     = 1'b0,
    REG_NOISE_MODE = 1'b1
  } reg_index_t;

  // Control from the pipeline to the stage register bank.
  typedef struct packed {
    logic update;  // item in the select stage is an enabled pink item
    logic commit;  // that item leaves the stage this cycle
  } bank_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/pink_white_noise_generator.sv =====
// Pink / white noise generator: top level with the configuration registers,
// the pipeline registers and flow control. Uses pwn_pkg and the pwn_* units.
//
// Usage:
//   Configuration is written through cfg_write / cfg_index / cfg_data:
//   index 0 is enable, index 1 is noise_mode (0 white, 1 pink). Write it
//   only while no beats are in flight.
//   Input beats (amplitude, rand_select, rand_value) are taken on item_valid
//   when item_stall is low; each yields one sample beat on sample_valid,
//   taken when sample_stall is low.
//   The pipeline has five registers: input, stage select/new value, stage
//   sum, amplitude product, output. A beat moves through them in that
//   order, and one beat is taken per cycle while item_stall is low.
//   The pink stage registers are written and summed in the same pipeline
//   stage, so consecutive beats see each other's updates with no wait.
//   When the receiver stalls, beats pile up into empty pipeline slots;
//   item_stall rises only when all five registers are full and the output
//   is stalled.
//   Reset clears the pipeline, the stages and both registers (disabled,
//   white mode).
`default_nettype none

module pink_white_noise_generator (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [0:0]         cfg_data,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire logic signed [15:0] amplitude,
  input  wire logic [15:0]        rand_select,
  input  wire logic [15:0]        rand_value,
  output logic                    sample_valid,
  input  wire logic               sample_stall,
  output logic signed [15:0]      sample
);

  // Configuration registers.
  logic enable;
  logic noise_mode;

  // Pipeline occupancy.
  logic in_full, sel_full, sum_full, prod_full;
  logic in_free, sel_free, sum_free, prod_free, out_free;
  logic accept, in_move, sel_move, sum_move, prod_move;

  // Input register.
  logic signed [15:0] in_amp;
  logic [15:0]        in_u1;
  logic [15:0]        in_u2;
  logic               in_en, in_pink;

  // Select stage register.
  logic signed [15:0]  sel_amp;
  logic [15:0]         sel_u1;
  pwn_pkg::stage_sel_t sel_stage;
  pwn_pkg::stage_val_t sel_new;
  logic                sel_en, sel_pink;

  // Sum stage register.
  logic signed [15:0] sum_amp;
  logic [15:0]        sum_u1;
  pwn_pkg::sum_t      sum_val;
  logic               sum_en, sum_pink;

  // Product stage register.
  pwn_pkg::prod_t prod_val;
  logic           prod_en, prod_pink;

  // Combinational results of the units.
  pwn_pkg::stage_sel_t stage_sel;
  pwn_pkg::stage_val_t stage_new;
  pwn_pkg::sum_t       stage_sum;
  pwn_pkg::prod_t      product;
  logic signed [15:0]  sample_next;
  pwn_pkg::bank_ctrl_t bank_ctrl;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      noise_mode <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        pwn_pkg::REG_ENABLE:     enable     <= cfg_data[0];
        pwn_pkg::REG_NOISE_MODE: noise_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Flow control: a slot is free if empty or if its beat moves on.
  always_comb begin
    out_free   = !sample_valid || !sample_stall;
    prod_free  = !prod_full || out_free;
    sum_free   = !sum_full || prod_free;
    sel_free   = !sel_full || sum_free;
    in_free    = !in_full || sel_free;
    item_stall = !in_free;
    accept     = item_valid && in_free;
    in_move    = in_full && sel_free;
    sel_move   = sel_full && sum_free;
    sum_move   = sum_full && prod_free;
    prod_move  = prod_full && out_free;
  end

  // Occupancy flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full      <= 1'b0;
      sel_full     <= 1'b0;
      sum_full     <= 1'b0;
      prod_full    <= 1'b0;
      sample_valid <= 1'b0;
    end else begin
      if (accept) in_full <= 1'b1;
      else if (in_move) in_full <= 1'b0;
      if (in_move) sel_full <= 1'b1;
      else if (sel_move) sel_full <= 1'b0;
      if (sel_move) sum_full <= 1'b1;
      else if (sum_move) sum_full <= 1'b0;
      if (sum_move) prod_full <= 1'b1;
      else if (prod_move) prod_full <= 1'b0;
      if (prod_move) sample_valid <= 1'b1;
      else if (!sample_stall) sample_valid <= 1'b0;
    end
  end

  // Input register, with the mode in force when the beat was taken.
  always_ff @(posedge clk) begin
    if (accept) begin
      in_amp  <= amplitude;
      in_u1   <= rand_select;
      in_u2   <= rand_value;
      in_en   <= enable;
      in_pink <= noise_mode;
    end
  end

  pwn_stage_sel u_stage_sel (
    .rand_select (in_u1),
    .rand_value  (in_u2),
    .stage_sel   (stage_sel),
    .stage_new   (stage_new)
  );

  // Select stage register.
  always_ff @(posedge clk) begin
    if (in_move) begin
      sel_amp   <= in_amp;
      sel_u1    <= in_u1;
      sel_stage <= stage_sel;
      sel_new   <= stage_new;
      sel_en    <= in_en;
      sel_pink  <= in_pink;
    end
  end

  // Stages update only for enabled pink beats.
  always_comb begin
    bank_ctrl.update = sel_full && sel_en && sel_pink;
    bank_ctrl.commit = bank_ctrl.update && sel_move;
  end

  pwn_stage_bank u_stage_bank (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (bank_ctrl),
    .stage_sel (sel_stage),
    .stage_new (sel_new),
    .stage_sum (stage_sum)
  );

  // Sum stage register.
  always_ff @(posedge clk) begin
    if (sel_move) begin
      sum_amp  <= sel_amp;
      sum_u1   <= sel_u1;
      sum_val  <= stage_sum;
      sum_en   <= sel_en;
      sum_pink <= sel_pink;
    end
  end

  pwn_scale_mul u_scale_mul (
    .amplitude   (sum_amp),
    .rand_select (sum_u1),
    .stage_sum   (sum_val),
    .pink        (sum_pink),
    .product     (product)
  );

  // Product stage register.
  always_ff @(posedge clk) begin
    if (sum_move) begin
      prod_val  <= product;
      prod_en   <= sum_en;
      prod_pink <= sum_pink;
    end
  end

  pwn_out_div u_out_div (
    .product     (prod_val),
    .enable      (prod_en),
    .pink        (prod_pink),
    .sample_next (sample_next)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (prod_move) begin
      sample <= sample_next;
    end
  end

  // The input side stalls only when every slot holds a beat.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (in_full && sel_full && sum_full && prod_full && sample_valid))
    else $error("item_stall with an empty pipeline slot");

  // A taken beat lands in the input register.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_full)
    else $error("accepted beat lost at the input register");

  // At most one stage is chosen per beat.
  a_sel_onehot: assert property (@(posedge clk) disable iff (rst)
    sel_full |-> $onehot0(sel_stage))
    else $error("more than one pink stage selected");

  // No stage is chosen only above the last threshold.
  a_sel_none: assert property (@(posedge clk) disable iff (rst)
    (sel_full && sel_en && sel_pink && (sel_stage == '0))
      |-> (sel_u1 > pwn_pkg::THRESH[pwn_pkg::NUM_STAGES-1]))
    else $error("no stage selected below the last threshold");

  // A delivered sample with nothing behind it leaves the output empty.
  a_out_drain: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall && !prod_full) |=> !sample_valid)
    else $error("sample repeated after delivery");

endmodule

`default_nettype wire

// ===== rtl/pwn_stage_sel.sv =====
// Stage selection and new stage value for the pink generator.
// Pure combinational logic; uses pwn_pkg tables and types.
`default_nettype none

module pwn_stage_sel (
  input  wire logic [15:0]         rand_select,
  input  wire logic [15:0]         rand_value,
  output pwn_pkg::stage_sel_t      stage_sel,
  output pwn_pkg::stage_val_t      stage_new
);

  logic               found;
  logic [14:0]        gain;
  logic signed [15:0] centered;
  logic signed [30:0] scaled;
  logic signed [30:0] rounded;

  // The first threshold that holds picks the stage and its gain.
  always_comb begin
    found     = 1'b0;
    stage_sel = '0;
    gain      = '0;
    for (int i = 0; i < pwn_pkg::NUM_STAGES; i++) begin
      if (!found && (rand_select <= pwn_pkg::THRESH[i])) begin
        stage_sel[i] = 1'b1;
        gain         = pwn_pkg::GAIN[i];
        found        = 1'b1;
      end
    end
  end

  // New value is (2*u2 - 1) * gain in Q3.12, rounded half up.
  always_comb begin
    centered  = $signed({~rand_value[15], rand_value[14:0]});
    scaled    = centered * $signed({1'b0, gain});
    rounded   = scaled + 31'(pwn_pkg::HALF_Q15);
    stage_new = rounded[30:15];
  end

endmodule

`default_nettype wire

// ===== rtl/pwn_stage_bank.sv =====
// Pink stage registers and the sum of the stages as seen after the update.
// Uses pwn_pkg types; written and read in the same pipeline stage.
`default_nettype none

module pwn_stage_bank (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire pwn_pkg::bank_ctrl_t ctrl,
  input  wire pwn_pkg::stage_sel_t stage_sel,
  input  wire pwn_pkg::stage_val_t stage_new,
  output pwn_pkg::sum_t            stage_sum
);

  pwn_pkg::stage_val_t stage_values [pwn_pkg::NUM_STAGES];
  pwn_pkg::stage_val_t stage_eff    [pwn_pkg::NUM_STAGES];

  // The selected stage is replaced when the item leaves the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pwn_pkg::NUM_STAGES; i++) begin
        stage_values[i] <= '0;
      end
    end else if (ctrl.commit) begin
      for (int i = 0; i < pwn_pkg::NUM_STAGES; i++) begin
        if (stage_sel[i]) begin
          stage_values[i] <= stage_new;
        end
      end
    end
  end

  // The sum uses the new value in place of the one it replaces.
  always_comb begin
    stage_sum = '0;
    for (int i = 0; i < pwn_pkg::NUM_STAGES; i++) begin
      stage_eff[i] = (ctrl.update && stage_sel[i]) ? stage_new : stage_values[i];
      stage_sum    = stage_sum + pwn_pkg::SUM_W'(stage_eff[i]);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pwn_scale_mul.sv =====
// Amplitude multiply: amplitude times the white value or the pink stage sum.
// Pure combinational logic; uses pwn_pkg types.
`default_nettype none

module pwn_scale_mul (
  input  wire logic signed [15:0] amplitude,
  input  wire logic [15:0]        rand_select,
  input  wire pwn_pkg::sum_t      stage_sum,
  input  wire logic               pink,
  output pwn_pkg::prod_t          product
);

  logic signed [15:0] white;
  pwn_pkg::sum_t      operand;

  // White value is (2*u1 - 1) in Q1.15; the pink operand is the Q3.12 sum.
  always_comb begin
    white   = $signed({~rand_select[15], rand_select[14:0]});
    operand = pink ? stage_sum : pwn_pkg::SUM_W'(white);
    product = amplitude * operand;
  end

endmodule

`default_nettype wire

// ===== rtl/pwn_out_div.sv =====
// Output scaling: rounding shift and saturation for white noise, division by
// 2048000 for pink noise via a reciprocal multiply. Uses pwn_pkg.
`default_nettype none

module pwn_out_div (
  input  wire pwn_pkg::prod_t     product,
  input  wire logic               enable,
  input  wire logic               pink,
  output logic signed [15:0]      sample_next
);

  pwn_pkg::prod_t     white_sum;
  pwn_pkg::prod_t     white_q;
  pwn_pkg::prod_t     pink_sum;
  pwn_pkg::prod_t     pink_q;
  logic [19:0]        dividend;
  logic [40:0]        recip_prod;
  logic [13:0]        quot;
  logic signed [14:0] pink_val;
  logic signed [15:0] white_val;

  // White: round half up at the Q1.15 point, then clamp.
  always_comb begin
    white_sum = product + pwn_pkg::PROD_W'(pwn_pkg::HALF_Q15);
    white_q   = white_sum >>> 15;
    if (white_q > pwn_pkg::PROD_W'(32767)) begin
      white_val = 16'sd32767;
    end else if (white_q < -pwn_pkg::PROD_W'(32768)) begin
      white_val = -16'sd32768;
    end else begin
      white_val = white_q[15:0];
    end
  end

  // Pink: floor((p + 1024000) / 2^14) then floor division by 125. The
  // offset of 125 * 4096 makes the dividend positive for the reciprocal.
  always_comb begin
    pink_sum   = product + pwn_pkg::PROD_W'(pwn_pkg::PINK_BIAS);
    pink_q     = pink_sum >>> pwn_pkg::PINK_SHIFT;
    dividend   = pink_q[19:0] + 20'(pwn_pkg::DIV_BIAS);
    recip_prod = 41'(dividend) * 41'(pwn_pkg::RECIP_125);
    quot       = recip_prod[40:pwn_pkg::RECIP_SHIFT];
    pink_val   = $signed({1'b0, quot}) - 15'(pwn_pkg::DIV_OFFSET);
  end

  // A disabled block outputs zero.
  always_comb begin
    if (!enable) begin
      sample_next = '0;
    end else if (pink) begin
      sample_next = 16'(pink_val);
    end else begin
      sample_next = white_val;
    end
  end

endmodule

`default_nettype wire
